// File: rtl/ordered_dither_column_pack_defines.svh
// Assertion macros shared by the ordered dither column packer.
`ifndef ORDERED_DITHER_COLUMN_PACK_DEFINES_SVH
`define ORDERED_DITHER_COLUMN_PACK_DEFINES_SVH

// Checked on every edge outside of reset.
`define ODCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ODCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/odcp_pkg.sv
// Shared types, constants and the Bayer threshold table of the column packer.
`timescale 1ns / 1ps

package odcp_pkg;

  // Field widths fixed by the interface.
  localparam int LANES       = 8;
  localparam int PIX_W       = 8;
  localparam int COLUMN_W    = 9;
  localparam int ROW_W       = 8;
  localparam int ROW_Y_W     = ROW_W + 1;
  localparam int RUN_W       = LANES * PIX_W;
  localparam int OFFSET_W    = 6;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Luma table geometry.
  localparam int LUMA_DEPTH = 256;
  localparam int LUMA_AW    = 8;

  // Default geometry of the tiled canvas.
  localparam int TILE_WIDTH_DEF   = 72;
  localparam int TILE_COLUMNS_DEF = 5;
  localparam int SOURCE_WIDTH_DEF = 320;

  // Reset values of the configuration registers.
  localparam logic [OFFSET_W-1:0] CANVAS_OFFSET_RST = 6'd20;
  localparam logic [ROW_W-1:0]    SOURCE_ROWS_RST   = 8'd200;
  localparam logic [ROW_W-1:0]    FRAME_ROWS_RST    = 8'd200;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_TABLE = 1'b1
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CANVAS_OFFSET = 2'd0,
    CFG_SOURCE_ROWS   = 2'd1,
    CFG_FRAME_ENABLE  = 2'd2,
    CFG_FRAME_ROWS    = 2'd3
  } cfg_index_t;

  // Configuration register set.
  typedef struct packed {
    logic [OFFSET_W-1:0] canvas_offset;
    logic [ROW_W-1:0]    source_rows;
    logic                frame_enable;
    logic [ROW_W-1:0]    frame_rows;
  } odcp_cfg_t;

  // Per-item decode results carried to the threshold stage.
  typedef struct packed {
    logic [LANES-1:0] dither_mask;
    logic [LANES-1:0] frame_mask;
    logic [1:0]       row_phase;
    logic [1:0]       col_phase;
  } odcp_ctl_t;

  // 4x4 Bayer thresholds, indexed by row phase then column phase.
  localparam logic [PIX_W-1:0] BAYER [4][4] = '{
    '{8'd8,   8'd136, 8'd40,  8'd168},
    '{8'd200, 8'd72,  8'd232, 8'd104},
    '{8'd56,  8'd184, 8'd24,  8'd152},
    '{8'd248, 8'd120, 8'd216, 8'd88}
  };

  function automatic logic [PIX_W-1:0] bayer_threshold(logic [1:0] row_ph,
                                                       logic [1:0] col_ph);
    return BAYER[row_ph][col_ph];
  endfunction

endpackage

// File: rtl/ordered_dither_column_pack.sv
// Ordered dither column packer top level: luma lookup, 4x4 Bayer compare, page byte.
// A pixel request fills the lookup stage registers, then the result register and out_valid.
// Throughput: one request per clock sustained while the result side does not stall.
// The rate is set by eight luma table copies, one read port per pixel lane.
// Reset clears the valid flags and loads configuration defaults; table contents stay unset.
`timescale 1ns / 1ps

`include "ordered_dither_column_pack_defines.svh"

module ordered_dither_column_pack import odcp_pkg::*; #(
  parameter int TILE_WIDTH   = TILE_WIDTH_DEF,
  parameter int TILE_COLUMNS = TILE_COLUMNS_DEF,
  parameter int SOURCE_WIDTH = SOURCE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Request channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   kind,
  input  logic [COLUMN_W-1:0]    canvas_column,
  input  logic [ROW_W-1:0]       row_base,
  input  logic [RUN_W-1:0]       pixel_run,
  input  logic [LUMA_AW-1:0]     table_index,
  input  logic [PIX_W-1:0]       table_value,
  // Result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIX_W-1:0]       page_byte
);

  odcp_cfg_t                   cfg;
  odcp_ctl_t                   dec_ctl;
  odcp_ctl_t                   s1_ctl;
  logic                        s1_valid;
  logic                        in_accept;
  logic                        pixel_accept;
  logic                        table_write;
  logic                        out_load;
  logic [LANES-1:0][PIX_W-1:0] luma;
  logic [LANES-1:0]            pack_bits;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.canvas_offset <= CANVAS_OFFSET_RST;
      cfg.source_rows   <= SOURCE_ROWS_RST;
      cfg.frame_enable  <= 1'b0;
      cfg.frame_rows    <= FRAME_ROWS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CANVAS_OFFSET: cfg.canvas_offset <= cfg_data[OFFSET_W-1:0];
        CFG_SOURCE_ROWS:   cfg.source_rows   <= cfg_data[ROW_W-1:0];
        CFG_FRAME_ENABLE:  cfg.frame_enable  <= cfg_data[0];
        CFG_FRAME_ROWS:    cfg.frame_rows    <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the lookup stage moves on whenever the result register is free.
  always_comb begin
    out_load     = s1_valid && (!out_valid || !out_stall);
    in_stall     = s1_valid && !out_load;
    in_accept    = in_valid && !in_stall;
    pixel_accept = in_accept && (kind == KIND_PIXEL);
    table_write  = in_accept && (kind == KIND_TABLE);
  end

  // Luma table, one copy per lane so all eight pixels are looked up together.
  for (genvar k = 0; k < LANES; k++) begin : g_luma
    odcp_ram #(
      .WIDTH (PIX_W),
      .DEPTH (LUMA_DEPTH)
    ) u_luma_ram (
      .clk     (clk),
      .wr_en   (table_write),
      .wr_addr (table_index),
      .wr_data (table_value),
      .rd_en   (pixel_accept),
      .rd_addr (pixel_run[k*PIX_W +: PIX_W]),
      .rd_data (luma[k])
    );
  end

  // Column and row decode, in parallel with the table read.
  odcp_decode #(
    .TILE_WIDTH   (TILE_WIDTH),
    .TILE_COLUMNS (TILE_COLUMNS),
    .SOURCE_WIDTH (SOURCE_WIDTH)
  ) u_decode (
    .canvas_column (canvas_column),
    .row_base      (row_base),
    .cfg           (cfg),
    .ctl           (dec_ctl)
  );

  // Lookup stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_ctl <= dec_ctl;
    end
  end

  // Threshold compare and packing.
  odcp_pack u_pack (
    .luma (luma),
    .ctl  (s1_ctl),
    .bits (pack_bits)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      page_byte <= pack_bits;
    end
  end

  // A result only enters the lookup stage from a pixel request.
  `ODCP_ASSERT(a_s1_from_pixel, $rose(s1_valid) |-> $past(in_valid && !in_stall && kind == KIND_PIXEL), "lookup stage filled without a pixel request")
  // The input only stalls while the lookup stage holds an item.
  `ODCP_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> s1_valid, "input stalled with an empty lookup stage")
  // Frame bits are always lit in the page byte.
  `ODCP_ASSERT(a_frame_lit, out_load |=> ((page_byte & $past(s1_ctl.frame_mask)) == $past(s1_ctl.frame_mask)), "frame bit missing from page byte")
  // Without dither lanes the byte is exactly the frame pattern.
  `ODCP_ASSERT(a_frame_only, (out_load && s1_ctl.dither_mask == '0) |=> page_byte == $past(s1_ctl.frame_mask), "dark lane lit outside the frame")

endmodule

// File: rtl/odcp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module odcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while reads are off.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/odcp_decode.sv
// Column and row decode: source window, dark rows and frame border per lane.
`timescale 1ns / 1ps

module odcp_decode import odcp_pkg::*; #(
  parameter int TILE_WIDTH   = TILE_WIDTH_DEF,
  parameter int TILE_COLUMNS = TILE_COLUMNS_DEF,
  parameter int SOURCE_WIDTH = SOURCE_WIDTH_DEF
) (
  input  logic [COLUMN_W-1:0] canvas_column,
  input  logic [ROW_W-1:0]    row_base,
  input  odcp_cfg_t           cfg,
  output odcp_ctl_t           ctl
);

  localparam int CanvasWidth = TILE_COLUMNS * TILE_WIDTH;
  // Wide enough for any column, the canvas width and the source width.
  localparam int CmpW = $clog2(CanvasWidth + SOURCE_WIDTH + 1024);

  logic [CmpW-1:0]    col_x;
  logic [CmpW-1:0]    offset_x;
  logic [CmpW-1:0]    src_x;
  logic               col_ok;
  logic               in_source;
  logic               side_col;
  logic [ROW_Y_W-1:0] src_rows_y;
  logic [ROW_Y_W-1:0] frame_rows_y;
  logic [ROW_Y_W-1:0] row_y [LANES];

  // Column tests shared by all eight lanes.
  always_comb begin
    col_x     = CmpW'(canvas_column);
    offset_x  = CmpW'(cfg.canvas_offset);
    src_x     = col_x - offset_x;
    col_ok    = col_x < CmpW'(CanvasWidth);
    in_source = (col_x >= offset_x) && (src_x < CmpW'(SOURCE_WIDTH));
    side_col  = (col_x <= CmpW'(1)) || (col_x + CmpW'(2) >= CmpW'(CanvasWidth));
  end

  // Per-lane row tests; rows run on past the base without wrapping.
  always_comb begin
    src_rows_y   = ROW_Y_W'(cfg.source_rows);
    frame_rows_y = ROW_Y_W'(cfg.frame_rows);
    for (int k = 0; k < LANES; k++) begin
      row_y[k] = ROW_Y_W'(row_base) + ROW_Y_W'(k);
      ctl.dither_mask[k] = col_ok && in_source && (row_y[k] < src_rows_y);
      ctl.frame_mask[k]  = col_ok && cfg.frame_enable && (row_y[k] < frame_rows_y) &&
                           ((row_y[k] <= ROW_Y_W'(1)) ||
                            (row_y[k] + ROW_Y_W'(2) > frame_rows_y) || side_col);
    end
    ctl.row_phase = row_base[1:0];
    ctl.col_phase = src_x[1:0];
  end

endmodule

// File: rtl/odcp_pack.sv
// Threshold compare of eight luma values and packing into one page byte.
`timescale 1ns / 1ps

module odcp_pack import odcp_pkg::*; (
  input  logic [LANES-1:0][PIX_W-1:0] luma,
  input  odcp_ctl_t                   ctl,
  output logic [LANES-1:0]            bits
);

  logic [1:0] lane_row_ph [LANES];

  // A pixel is lit when dithered with luma over the Bayer threshold, or framed.
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_row_ph[k] = ctl.row_phase + 2'(k);
      bits[k] = (ctl.dither_mask[k] &&
                 (luma[k] > bayer_threshold(lane_row_ph[k], ctl.col_phase))) ||
                ctl.frame_mask[k];
    end
  end

endmodule
